/* rtl/core/cub_pkg.sv */
// ----------------------------------------------------------------------------
// cub_pkg
// Shared types and constants of the console UART ring buffers: request
// function codes, internal operation codes and the queued request record.
// ----------------------------------------------------------------------------
package cub_pkg;

  // Function codes on the request port
  localparam logic [2:0] FUNC_RX_BYTE  = 3'd0;
  localparam logic [2:0] FUNC_HOST_WR  = 3'd1;
  localparam logic [2:0] FUNC_HOST_RD  = 3'd2;
  localparam logic [2:0] FUNC_TX_RDY   = 3'd3;
  localparam logic [2:0] FUNC_OVERRUN  = 3'd4;
  localparam logic [2:0] FUNC_CLR_RX   = 3'd5;
  localparam logic [2:0] FUNC_CLR_TX   = 3'd6;

  // Operation codes after classification
  typedef logic [2:0] cub_op_t;
  localparam cub_op_t OP_NOP     = 3'd0;
  localparam cub_op_t OP_RX_BYTE = 3'd1;
  localparam cub_op_t OP_HOST_WR = 3'd2;
  localparam cub_op_t OP_HOST_RD = 3'd3;
  localparam cub_op_t OP_TX_RDY  = 3'd4;
  localparam cub_op_t OP_OVERRUN = 3'd5;
  localparam cub_op_t OP_CLR_RX  = 3'd6;
  localparam cub_op_t OP_CLR_TX  = 3'd7;

  // Characters
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] NEWLINE_RESET = 8'd10;

  // Queued request between front and back
  typedef struct packed {
    cub_op_t    op;
    logic [7:0] data;
  } cub_req_t;

endpackage

/* rtl/core/cub_front.sv */
// ----------------------------------------------------------------------------
// cub_front
// Request front end: accepts requests, classifies the function code and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cub_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_func,
  input  logic [7:0]        in_data_byte,
  output logic              busy,
  output logic              req_valid,
  output cub_pkg::cub_req_t req,
  input  logic              req_pop
);
  import cub_pkg::*;

  cub_req_t   q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  cub_req_t   cls;

  // Classify the function code
  always_comb begin
    cls.data = in_data_byte;
    unique case (in_func)
      FUNC_RX_BYTE: cls.op = OP_RX_BYTE;
      FUNC_HOST_WR: cls.op = OP_HOST_WR;
      FUNC_HOST_RD: cls.op = OP_HOST_RD;
      FUNC_TX_RDY:  cls.op = OP_TX_RDY;
      FUNC_OVERRUN: cls.op = OP_OVERRUN;
      FUNC_CLR_RX:  cls.op = OP_CLR_RX;
      FUNC_CLR_TX:  cls.op = OP_CLR_TX;
      default:      cls.op = OP_NOP;
    endcase
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign req_valid = (cnt_r != 2'd0);
  assign pop       = req_pop && req_valid;
  assign req       = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Store the classified request
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* rtl/core/cub_back.sv */
// ----------------------------------------------------------------------------
// cub_back
// Request back end: owns the receive and transmit rings, carries out each
// queued request and emits one result strobe per request.
// ----------------------------------------------------------------------------
module cub_back #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  cub_pkg::cub_req_t req,
  output logic              req_pop,
  input  logic [7:0]        newline_char,
  output logic              out_strobe,
  output logic              out_line_valid,
  output logic [7:0]        out_line_byte,
  output logic              out_read_valid,
  output logic [7:0]        out_read_byte,
  output logic [7:0]        out_newline_count,
  output logic              out_flag_read,
  output logic              out_rx_overflow,
  output logic              out_tx_overflow
);
  import cub_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = (PW > 8) ? PW : 8;
  localparam logic [PW-1:0] LAST_PTR = PW'(BUFFER_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_RXRD = 2'd2;
  localparam logic [1:0] ST_TXRD = 2'd3;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  logic [7:0]    rx_mem [BUFFER_DEPTH];
  logic [7:0]    tx_mem [BUFFER_DEPTH];
  logic [7:0]    rx_rd_r;
  logic [7:0]    tx_rd_r;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] rx_wp_r, rx_wp_nxt;
  logic [PW-1:0] rx_rp_r, rx_rp_nxt;
  logic [PW-1:0] tx_wp_r, tx_wp_nxt;
  logic [PW-1:0] tx_rp_r, tx_rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    last_r, last_nxt;
  logic          rx_ovf_r, rx_ovf_nxt;
  logic          tx_ovf_r, tx_ovf_nxt;
  logic [7:0]    hold_r, hold_nxt;

  logic          strobe_r, strobe_nxt;
  logic          line_valid_r, line_valid_nxt;
  logic [7:0]    line_byte_r, line_byte_nxt;
  logic          read_valid_r, read_valid_nxt;
  logic [7:0]    read_byte_r, read_byte_nxt;
  logic          flag_r, flag_nxt;

  logic [PW-1:0] rx_wnx, rx_rnx, tx_wnx, tx_rnx;
  logic          rx_we, tx_we;
  logic [7:0]    tx_wdata;
  logic          push_en;
  logic [7:0]    push_byte;
  logic          need_lf;

  assign rx_wnx  = next_ptr(rx_wp_r);
  assign rx_rnx  = next_ptr(rx_rp_r);
  assign tx_wnx  = next_ptr(tx_wp_r);
  assign tx_rnx  = next_ptr(tx_rp_r);
  assign need_lf = (last_r == CH_CR) && (req.data != CH_LF);

  // Sequence requests
  always_comb begin
    state_nxt      = state_r;
    rx_wp_nxt      = rx_wp_r;
    rx_rp_nxt      = rx_rp_r;
    tx_rp_nxt      = tx_rp_r;
    cnt_nxt        = cnt_r;
    rx_ovf_nxt     = rx_ovf_r;
    hold_nxt       = hold_r;
    strobe_nxt     = 1'b0;
    line_valid_nxt = 1'b0;
    line_byte_nxt  = 8'd0;
    read_valid_nxt = 1'b0;
    read_byte_nxt  = 8'd0;
    flag_nxt       = 1'b0;
    req_pop        = 1'b0;
    rx_we          = 1'b0;
    push_en        = 1'b0;
    push_byte      = req.data;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          unique case (req.op) inside
            OP_RX_BYTE, OP_HOST_WR: begin
              if (req.op == OP_RX_BYTE && rx_wnx == rx_rp_r) begin
                // drop: receive ring full
                rx_ovf_nxt = 1'b1;
                strobe_nxt = 1'b1;
              end else begin
                if (req.op == OP_RX_BYTE) begin
                  rx_we     = 1'b1;
                  rx_wp_nxt = rx_wnx;
                  if (req.data == newline_char) begin
                    cnt_nxt = cnt_r + CW'(1);
                  end
                end
                push_en = 1'b1;
                if (need_lf) begin
                  push_byte = CH_LF;
                  hold_nxt  = req.data;
                  state_nxt = ST_PUSH;
                end else begin
                  strobe_nxt = 1'b1;
                end
              end
            end
            OP_HOST_RD: begin
              if (rx_rp_r != rx_wp_r) begin
                rx_rp_nxt = rx_rnx;
                state_nxt = ST_RXRD;
              end else begin
                strobe_nxt = 1'b1;
              end
            end
            OP_TX_RDY: begin
              if (tx_rp_r != tx_wp_r) begin
                tx_rp_nxt = tx_rnx;
                state_nxt = ST_TXRD;
              end else begin
                strobe_nxt = 1'b1;
              end
            end
            OP_OVERRUN: begin
              rx_ovf_nxt = 1'b1;
              strobe_nxt = 1'b1;
            end
            OP_CLR_RX: begin
              flag_nxt   = rx_ovf_r;
              rx_ovf_nxt = 1'b0;
              strobe_nxt = 1'b1;
            end
            OP_CLR_TX: begin
              flag_nxt   = tx_ovf_r;
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_PUSH: begin
        // push the held byte after the inserted LF
        push_en    = 1'b1;
        push_byte  = hold_r;
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RXRD: begin
        read_valid_nxt = 1'b1;
        read_byte_nxt  = rx_rd_r;
        if (rx_rd_r == newline_char && cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
        end
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_TXRD: begin
        line_valid_nxt = 1'b1;
        line_byte_nxt  = tx_rd_r;
        strobe_nxt     = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Transmit ring push and transmit overflow flag
  always_comb begin
    tx_we      = 1'b0;
    tx_wdata   = push_byte;
    tx_wp_nxt  = tx_wp_r;
    last_nxt   = last_r;
    tx_ovf_nxt = tx_ovf_r;
    if (state_r == ST_IDLE && req_valid && req.op == OP_CLR_TX) begin
      tx_ovf_nxt = 1'b0;
    end
    if (push_en) begin
      if (tx_wnx == tx_rp_r) begin
        tx_ovf_nxt = 1'b1;
      end else begin
        tx_we     = 1'b1;
        tx_wp_nxt = tx_wnx;
        last_nxt  = push_byte;
      end
    end
  end

  // Control and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rx_wp_r      <= '0;
      rx_rp_r      <= '0;
      tx_wp_r      <= '0;
      tx_rp_r      <= '0;
      cnt_r        <= '0;
      last_r       <= 8'd0;
      rx_ovf_r     <= 1'b0;
      tx_ovf_r     <= 1'b0;
      strobe_r     <= 1'b0;
      line_valid_r <= 1'b0;
      read_valid_r <= 1'b0;
      flag_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rx_wp_r      <= rx_wp_nxt;
      rx_rp_r      <= rx_rp_nxt;
      tx_wp_r      <= tx_wp_nxt;
      tx_rp_r      <= tx_rp_nxt;
      cnt_r        <= cnt_nxt;
      last_r       <= last_nxt;
      rx_ovf_r     <= rx_ovf_nxt;
      tx_ovf_r     <= tx_ovf_nxt;
      strobe_r     <= strobe_nxt;
      line_valid_r <= line_valid_nxt;
      read_valid_r <= read_valid_nxt;
      flag_r       <= flag_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hold_r      <= hold_nxt;
    line_byte_r <= line_byte_nxt;
    read_byte_r <= read_byte_nxt;
  end

  // Ring stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wnx] <= req.data;
    end
    rx_rd_r <= rx_mem[rx_rnx];
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wnx] <= tx_wdata;
    end
    tx_rd_r <= tx_mem[tx_rnx];
  end

  assign out_strobe        = strobe_r;
  assign out_line_valid    = line_valid_r;
  assign out_line_byte     = line_byte_r;
  assign out_read_valid    = read_valid_r;
  assign out_read_byte     = read_byte_r;
  assign out_flag_read     = flag_r;
  assign out_rx_overflow   = rx_ovf_r;
  assign out_tx_overflow   = tx_ovf_r;
  assign out_newline_count = (cnt_r > CW'(255)) ? 8'hFF : cnt_r[7:0];

endmodule

/* rtl/core/console_uart_ring_buffers.sv */
// ----------------------------------------------------------------------------
// console_uart_ring_buffers
// Console UART front end with receive and transmit rings, receive echo,
// CR-LF insertion on host writes and echoed bytes and read-and-clear overflow flags.
// ----------------------------------------------------------------------------
// Channel   Ports                            Handshake
// request   start, in_func, in_data_byte     taken when start && !busy
// result    out_strobe, out_*                one cycle at out_strobe, no stall
// config    cfg_we, cfg_wdata                written when cfg_we
//
// With the back end free, a request waits in the two-entry queue, then the
// back end takes it in ST_IDLE and answers from there, or passes through a
// second state when it pops a ring (ST_RXRD/ST_TXRD, registered store read)
// or when an LF is inserted before a host or echoed byte (ST_PUSH). The
// strobe is registered from the last of these states; a request behind
// others in the queue also waits for each of them. The back end sequencer
// takes no new request until it is back in ST_IDLE. busy rises when the
// queue holds two requests. Reset empties both rings and clears flags; no clearing pass.
// ----------------------------------------------------------------------------
module console_uart_ring_buffers #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_func,
  input  logic [7:0] in_data_byte,
  output logic       out_strobe,
  output logic       out_line_valid,
  output logic [7:0] out_line_byte,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic [7:0] out_newline_count,
  output logic       out_flag_read,
  output logic       out_rx_overflow,
  output logic       out_tx_overflow,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import cub_pkg::*;

  logic       req_valid;
  logic       req_pop;
  cub_req_t   req;
  logic [7:0] newline_char_r;

  // Newline character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newline_char_r <= NEWLINE_RESET;
    end else if (cfg_we) begin
      newline_char_r <= cfg_wdata;
    end
  end

  cub_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .busy         (busy),
    .req_valid    (req_valid),
    .req          (req),
    .req_pop      (req_pop)
  );

  cub_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_valid),
    .req               (req),
    .req_pop           (req_pop),
    .newline_char      (newline_char_r),
    .out_strobe        (out_strobe),
    .out_line_valid    (out_line_valid),
    .out_line_byte     (out_line_byte),
    .out_read_valid    (out_read_valid),
    .out_read_byte     (out_read_byte),
    .out_newline_count (out_newline_count),
    .out_flag_read     (out_flag_read),
    .out_rx_overflow   (out_rx_overflow),
    .out_tx_overflow   (out_tx_overflow)
  );

  // Result qualifiers only appear with the strobe
  a_line_valid_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_line_valid |-> out_strobe)
    else $error("line valid without result strobe");

  a_read_valid_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_read_valid |-> out_strobe)
    else $error("read valid without result strobe");

  // One request never pops both rings
  a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_line_valid && out_read_valid))
    else $error("line and read pops in one result");

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("busy or strobe right after reset");

endmodule
